@@ rtl/hvn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_pkg
// Types and constants shared by the heightmap vertex/normal block.
// ----------------------------------------------------------------------------
package hvn_pkg;

   localparam int COORD_W    = 12;
   localparam int HT_W       = 8;
   localparam int DIM_W      = 13;
   localparam int SCALE_W    = 16;
   localparam int POS_W      = 32;
   localparam int NORM_W     = 16;
   localparam int TEXEL_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int C_W        = 42;
   localparam int MAG_W      = 31;
   localparam int SH_MAX     = C_W - 1 - MAG_W;
   localparam int SQ_STEPS   = 32;
   localparam int ROOT_W     = 32;
   localparam int REM_W      = 36;
   localparam int DV_STEPS   = 15;
   localparam int NUM_W      = 48;
   localparam int NST        = 5 + (SQ_STEPS + 1) + (DV_STEPS + 1) + 1;

   localparam logic [DIM_W-1:0]   DIM_RESET   = 13'd256;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
   localparam logic [NORM_W-1:0]  NORM_ONE    = 16'd16384;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_WIDTH  = 3'd0,
      CSR_MAP_HEIGHT = 3'd1,
      CSR_SCALE_X    = 3'd2,
      CSR_SCALE_Y    = 3'd3,
      CSR_SCALE_Z    = 3'd4
   } hvn_csr_type;

   typedef struct packed {
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [POS_W-1:0]   pos_z;
      logic [TEXEL_W-1:0] texel;
      logic               border;
      logic [2:0]         neg;
   } hvn_side_type;

endpackage

@@ rtl/hvn_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_if
// Valid/ready channels of the heightmap vertex/normal block.
// ----------------------------------------------------------------------------
interface hvn_req_if import hvn_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] column;
   logic [COORD_W-1:0] row_index;
   logic [HT_W-1:0]    height_center;
   logic [HT_W-1:0]    height_up;
   logic [HT_W-1:0]    height_down;
   logic [HT_W-1:0]    height_left;
   logic [HT_W-1:0]    height_right;
   logic [TEXEL_W-1:0] texel_in;
   modport source(output valid, column, row_index, height_center, height_up, height_down,
                  height_left, height_right, texel_in, input ready);
   modport sink(input valid, column, row_index, height_center, height_up, height_down,
                height_left, height_right, texel_in, output ready);
endinterface

interface hvn_rsp_if import hvn_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [POS_W-1:0]  pos_x;
   logic signed [POS_W-1:0]  pos_y;
   logic signed [POS_W-1:0]  pos_z;
   logic signed [NORM_W-1:0] norm_x;
   logic signed [NORM_W-1:0] norm_y;
   logic signed [NORM_W-1:0] norm_z;
   logic [TEXEL_W-1:0]       texel_out;
   modport source(output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, texel_out,
                  input ready);
   modport sink(input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, texel_out,
                output ready);
endinterface

interface hvn_csr_if import hvn_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/heightmap_vertex_normal.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_vertex_normal
// One heightmap pixel in, one terrain vertex (position, unit normal, texel) out.
// ----------------------------------------------------------------------------
// The normal path runs through the 32-stage square-root chain and then the
// 15-stage divider chain.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous; empties the pipeline and restores map size 256 x 256
// and all scales to 1.0.
module heightmap_vertex_normal import hvn_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input logic         clock,
   input logic         reset,
   hvn_req_if.sink     req_if,
   hvn_rsp_if.source   rsp_if,
   hvn_csr_if.sink     csr_if
);

   logic [DIM_W-1:0]          map_width_ff, map_height_ff;
   logic signed [SCALE_W-1:0] scale_x_ff, scale_y_ff, scale_z_ff;
   logic [DIM_W-1:0]          w_eff, h_eff;

   logic [NST-1:0] vld_ff;
   logic           adv;

   // stage 1
   logic signed [30:0] s1_px_ff, s1_pz_ff;
   logic signed [24:0] s1_py_ff;
   logic signed [31:0] s1_pzy_ff, s1_pzx_ff, s1_pxy_ff;
   logic signed [8:0]  s1_drl_ff, s1_ddu_ff;
   logic               s1_border_ff;
   logic [TEXEL_W-1:0] s1_texel_ff;
   logic signed [14:0] dx2, dz2;
   logic               border_in;

   // stage 2
   logic [POS_W-1:0]        s2_posx_ff, s2_posz_ff;
   logic [23:0]             s2_v_ff;
   logic [32:0]             s2_t_ff;
   logic                    s2_negy_ff;
   logic signed [C_W-1:0]   s2_c_ff [0:2];
   logic                    s2_border_ff;
   logic [TEXEL_W-1:0]      s2_texel_ff;
   logic [23:0]             my_in;
   logic signed [C_W-1:0]   c_in [0:2];

   // stage 3
   hvn_side_type      s3_side_ff;
   logic [C_W-2:0]    s3_mag_ff [0:2];
   logic [16:0]       q0;
   logic [24:0]       ry;
   logic [16:0]       qy;
   logic [POS_W-1:0]  posy_in;

   // stage 4, 5
   hvn_side_type      s4_side_ff, s5_side_ff;
   logic [MAG_W-1:0]  s4_m_ff [0:2];
   logic [MAG_W-1:0]  s5_m_ff [0:2];
   logic [2*MAG_W-1:0] s5_sq_ff [0:2];
   logic [C_W-2:0]    mx;
   int unsigned       sh;

   // square root chain, element 0 is the sum-of-squares stage
   logic [63:0]       sq_val_ff  [0:SQ_STEPS];
   logic [REM_W-1:0]  sq_rem_ff  [0:SQ_STEPS];
   logic [ROOT_W-1:0] sq_root_ff [0:SQ_STEPS];
   hvn_side_type      sq_side_ff [0:SQ_STEPS];
   logic [MAG_W-1:0]  sq_m_ff    [0:SQ_STEPS][0:2];
   logic [63:0]       sq_val_in  [1:SQ_STEPS];
   logic [REM_W-1:0]  sq_rem_in  [1:SQ_STEPS];
   logic [ROOT_W-1:0] sq_root_in [1:SQ_STEPS];

   // divider chain, element 0 loads numerators and divisor
   logic [NUM_W-1:0]    dv_rem_ff [0:DV_STEPS][0:2];
   logic [DV_STEPS-1:0] dv_q_ff   [0:DV_STEPS][0:2];
   logic [ROOT_W:0]     dv_d_ff   [0:DV_STEPS];
   hvn_side_type        dv_side_ff [0:DV_STEPS];
   logic [NUM_W-1:0]    dv_rem_in [1:DV_STEPS][0:2];
   logic [DV_STEPS-1:0] dv_q_in   [1:DV_STEPS][0:2];

   // output
   hvn_side_type      out_side_ff;
   logic [NORM_W-1:0] out_norm_ff [0:2];
   logic [NORM_W-1:0] norm_in [0:2];

   function automatic logic [POS_W-1:0] rnd_half(input logic signed [30:0] p);
      logic [30:0]      mag;
      logic [POS_W-1:0] q;
      mag = p[30] ? (~p + 31'd1) : p;
      q = (32'(mag) + 32'd1) >> 1;
      return p[30] ? (~q + 32'd1) : q;
   endfunction

   // configuration
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= DIM_RESET;
         map_height_ff <= DIM_RESET;
         scale_x_ff    <= SCALE_RESET;
         scale_y_ff    <= SCALE_RESET;
         scale_z_ff    <= SCALE_RESET;
      end else if (csr_if.valid) begin
         case (hvn_csr_type'(csr_if.index))
            CSR_MAP_WIDTH:  map_width_ff  <= csr_if.data[DIM_W-1:0];
            CSR_MAP_HEIGHT: map_height_ff <= csr_if.data[DIM_W-1:0];
            CSR_SCALE_X:    scale_x_ff    <= csr_if.data;
            CSR_SCALE_Y:    scale_y_ff    <= csr_if.data;
            CSR_SCALE_Z:    scale_z_ff    <= csr_if.data;
            default: ;
         endcase
      end
   end

   assign w_eff = (32'(map_width_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : map_width_ff;
   assign h_eff = (32'(map_height_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : map_height_ff;

   // handshake
   assign adv          = !vld_ff[NST-1] || rsp_if.ready;
   assign req_if.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_if.valid};
      end
   end

   // stage 1 logic
   assign dx2 = $signed({2'b00, req_if.column, 1'b0}) - $signed({2'b00, w_eff});
   assign dz2 = $signed({2'b00, req_if.row_index, 1'b0}) - $signed({2'b00, h_eff});
   assign border_in = (req_if.column == '0) || (req_if.row_index == '0)
                   || (({2'b00, req_if.column} + 14'd1) >= {1'b0, w_eff})
                   || (({2'b00, req_if.row_index} + 14'd1) >= {1'b0, h_eff});

   // stage 2 logic
   always_comb begin
      my_in   = s1_py_ff[24] ? 24'(~s1_py_ff + 25'd1) : 24'(s1_py_ff);
      c_in[0] = -(C_W'(s1_pzy_ff) * C_W'(s1_drl_ff));
      c_in[1] = C_W'(s1_pzx_ff) * C_W'(11'sd510);
      c_in[2] = -(C_W'(s1_pxy_ff) * C_W'(s1_ddu_ff));
   end

   // stage 3 logic: height divide by 255 via reciprocal and correction
   always_comb begin
      q0 = s2_t_ff[32:16];
      ry = {1'b0, s2_v_ff} - (25'(q0) * 25'd255);
      if (ry >= 25'd510) begin
         qy = q0 + 17'd2;
      end else if (ry >= 25'd255) begin
         qy = q0 + 17'd1;
      end else begin
         qy = q0;
      end
      posy_in = s2_negy_ff ? (~32'(qy) + 32'd1) : 32'(qy);
   end

   // stage 4 logic: common shift to bring magnitudes under 2^31
   always_comb begin
      mx = s3_mag_ff[0];
      if (s3_mag_ff[1] > mx) mx = s3_mag_ff[1];
      if (s3_mag_ff[2] > mx) mx = s3_mag_ff[2];
      sh = 0;
      for (int s = SH_MAX; s >= 0; s--) begin
         if ((mx >> s) < ((C_W-1)'(1) << MAG_W)) sh = s;
      end
   end

   // square root and divider steps
   always_comb begin
      logic [REM_W-1:0] rs;
      logic [REM_W-1:0] tr;
      logic [NUM_W-1:0] cv;
      for (int k = 1; k <= SQ_STEPS; k++) begin
         rs = {sq_rem_ff[k-1][REM_W-3:0], sq_val_ff[k-1][63:62]};
         tr = REM_W'({sq_root_ff[k-1], 2'b01});
         sq_val_in[k] = {sq_val_ff[k-1][61:0], 2'b00};
         if (rs >= tr) begin
            sq_rem_in[k]  = rs - tr;
            sq_root_in[k] = {sq_root_ff[k-1][ROOT_W-2:0], 1'b1};
         end else begin
            sq_rem_in[k]  = rs;
            sq_root_in[k] = {sq_root_ff[k-1][ROOT_W-2:0], 1'b0};
         end
      end
      for (int k = 1; k <= DV_STEPS; k++) begin
         cv = NUM_W'(dv_d_ff[k-1]) << (DV_STEPS - k);
         for (int i = 0; i < 3; i++) begin
            if (dv_rem_ff[k-1][i] >= cv) begin
               dv_rem_in[k][i] = dv_rem_ff[k-1][i] - cv;
               dv_q_in[k][i]   = {dv_q_ff[k-1][i][DV_STEPS-2:0], 1'b1};
            end else begin
               dv_rem_in[k][i] = dv_rem_ff[k-1][i];
               dv_q_in[k][i]   = {dv_q_ff[k-1][i][DV_STEPS-2:0], 1'b0};
            end
         end
      end
   end

   // output normal select
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_side_ff[DV_STEPS].border) begin
            norm_in[i] = (i == 1) ? NORM_ONE : '0;
         end else if (dv_d_ff[DV_STEPS] == '0) begin
            norm_in[i] = '0;
         end else if (dv_side_ff[DV_STEPS].neg[i]) begin
            norm_in[i] = ~NORM_W'(dv_q_ff[DV_STEPS][i]) + 16'd1;
         end else begin
            norm_in[i] = NORM_W'(dv_q_ff[DV_STEPS][i]);
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_px_ff     <= 31'(scale_x_ff) * 31'(dx2);
         s1_pz_ff     <= 31'(scale_z_ff) * 31'(dz2);
         s1_py_ff     <= 25'(scale_y_ff) * 25'($signed({1'b0, req_if.height_center}));
         s1_pzy_ff    <= 32'(scale_z_ff) * 32'(scale_y_ff);
         s1_pzx_ff    <= 32'(scale_z_ff) * 32'(scale_x_ff);
         s1_pxy_ff    <= 32'(scale_x_ff) * 32'(scale_y_ff);
         s1_drl_ff    <= $signed({1'b0, req_if.height_right}) - $signed({1'b0, req_if.height_left});
         s1_ddu_ff    <= $signed({1'b0, req_if.height_down}) - $signed({1'b0, req_if.height_up});
         s1_border_ff <= border_in;
         s1_texel_ff  <= req_if.texel_in;

         s2_posx_ff   <= rnd_half(s1_px_ff);
         s2_posz_ff   <= rnd_half(s1_pz_ff);
         s2_v_ff      <= my_in + 24'd127;
         s2_t_ff      <= 33'(my_in + 24'd127) * 33'd257;
         s2_negy_ff   <= s1_py_ff[24];
         s2_border_ff <= s1_border_ff;
         s2_texel_ff  <= s1_texel_ff;
         for (int i = 0; i < 3; i++) s2_c_ff[i] <= c_in[i];

         s3_side_ff.pos_x  <= s2_posx_ff;
         s3_side_ff.pos_y  <= posy_in;
         s3_side_ff.pos_z  <= s2_posz_ff;
         s3_side_ff.texel  <= s2_texel_ff;
         s3_side_ff.border <= s2_border_ff;
         for (int i = 0; i < 3; i++) begin
            s3_side_ff.neg[i] <= s2_c_ff[i][C_W-1];
            s3_mag_ff[i] <= s2_c_ff[i][C_W-1] ? (C_W-1)'(~s2_c_ff[i] + 1'b1)
                                              : (C_W-1)'(s2_c_ff[i]);
         end

         s4_side_ff <= s3_side_ff;
         for (int i = 0; i < 3; i++) s4_m_ff[i] <= MAG_W'(s3_mag_ff[i] >> sh);

         s5_side_ff <= s4_side_ff;
         for (int i = 0; i < 3; i++) begin
            s5_m_ff[i]  <= s4_m_ff[i];
            s5_sq_ff[i] <= (2*MAG_W)'(s4_m_ff[i]) * (2*MAG_W)'(s4_m_ff[i]);
         end

         sq_val_ff[0]  <= 64'(s5_sq_ff[0]) + 64'(s5_sq_ff[1]) + 64'(s5_sq_ff[2]);
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_side_ff[0] <= s5_side_ff;
         for (int i = 0; i < 3; i++) sq_m_ff[0][i] <= s5_m_ff[i];
         for (int k = 1; k <= SQ_STEPS; k++) begin
            sq_val_ff[k]  <= sq_val_in[k];
            sq_rem_ff[k]  <= sq_rem_in[k];
            sq_root_ff[k] <= sq_root_in[k];
            sq_side_ff[k] <= sq_side_ff[k-1];
            for (int i = 0; i < 3; i++) sq_m_ff[k][i] <= sq_m_ff[k-1][i];
         end

         dv_d_ff[0]    <= {sq_root_ff[SQ_STEPS], 1'b0};
         dv_side_ff[0] <= sq_side_ff[SQ_STEPS];
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= NUM_W'({sq_m_ff[SQ_STEPS][i], 15'd0})
                             + NUM_W'(sq_root_ff[SQ_STEPS]);
            dv_q_ff[0][i]   <= '0;
         end
         for (int k = 1; k <= DV_STEPS; k++) begin
            dv_d_ff[k]    <= dv_d_ff[k-1];
            dv_side_ff[k] <= dv_side_ff[k-1];
            for (int i = 0; i < 3; i++) begin
               dv_rem_ff[k][i] <= dv_rem_in[k][i];
               dv_q_ff[k][i]   <= dv_q_in[k][i];
            end
         end

         out_side_ff <= dv_side_ff[DV_STEPS];
         for (int i = 0; i < 3; i++) out_norm_ff[i] <= norm_in[i];
      end
   end

   assign rsp_if.valid     = vld_ff[NST-1];
   assign rsp_if.pos_x     = out_side_ff.pos_x;
   assign rsp_if.pos_y     = out_side_ff.pos_y;
   assign rsp_if.pos_z     = out_side_ff.pos_z;
   assign rsp_if.norm_x    = out_norm_ff[0];
   assign rsp_if.norm_y    = out_norm_ff[1];
   assign rsp_if.norm_z    = out_norm_ff[2];
   assign rsp_if.texel_out = out_side_ff.texel;

   // assertions
   a_border_norm: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NST-1] && out_side_ff.border |->
         out_norm_ff[0] == '0 && out_norm_ff[1] == NORM_ONE && out_norm_ff[2] == '0)
      else $error("border item without up normal");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NST-1] |->
         ($signed(out_norm_ff[0]) <= 16384 && $signed(out_norm_ff[0]) >= -16384) &&
         ($signed(out_norm_ff[2]) <= 16384 && $signed(out_norm_ff[2]) >= -16384))
      else $error("normal component out of range");

   a_sqrt_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[6 + SQ_STEPS - 1] |->
         sq_rem_ff[SQ_STEPS] <= REM_W'({sq_root_ff[SQ_STEPS], 1'b0}))
      else $error("square root remainder too large");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NST-1] && !rsp_if.ready |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

endmodule
